>>> rtl/lcb_pkg.sv
// Package for the LRU byte-budget table: sizes, command and status codes,
// and the structs passed between the sequencer and the entry cells.
// No dependencies.
package lcb_pkg;

  localparam int DEPTH       = 16;
  localparam int IW          = $clog2(DEPTH);
  localparam int KEY_BITS    = 32;
  localparam int HANDLE_BITS = 16;
  localparam int SIZE_BITS   = 24;
  localparam int BYTES_BITS  = 28;

  localparam logic [BYTES_BITS-1:0] BYTES_MAX   = {BYTES_BITS{1'b1}};
  localparam logic [BYTES_BITS-1:0] LIMIT_RESET = BYTES_BITS'(67108864);

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_LOOKUP  = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_EVICTED  = 3'd2;
  localparam logic [2:0] ST_STORED   = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;
  localparam logic [2:0] ST_ADVANCED = 3'd5;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
    logic [SIZE_BITS-1:0]   size;
    logic [IW-1:0]          walk_rank;
    logic                   evict;
    logic [IW-1:0]          sel_idx;
    logic                   wr;
    logic                   promote;
    logic [IW-1:0]          promote_rank;
    logic                   clr_batch;
  } lcb_ctrl_t;

  // what each cell reports back
  typedef struct packed {
    logic                   hit;
    logic                   walk_hit;
    logic                   valid;
    logic                   batch;
    logic [IW-1:0]          rank;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
    logic [SIZE_BITS-1:0]   size;
  } lcb_cell_t;

  function automatic logic [BYTES_BITS-1:0] sat_add(input logic [BYTES_BITS-1:0] t,
                                                    input logic [SIZE_BITS-1:0] v);
    logic [BYTES_BITS:0] s;
    s = {1'b0, t} + (BYTES_BITS+1)'(v);
    return s[BYTES_BITS] ? BYTES_MAX : s[BYTES_BITS-1:0];
  endfunction

  function automatic logic [BYTES_BITS-1:0] sat_sub(input logic [BYTES_BITS-1:0] t,
                                                    input logic [SIZE_BITS-1:0] v);
    logic [BYTES_BITS-1:0] w;
    w = BYTES_BITS'(v);
    return (w > t) ? '0 : t - w;
  endfunction

endpackage

>>> rtl/lcb_cell.sv
// One table entry: key, handle, size, valid and batch flags and recency rank.
// Depends on lcb_pkg.
module lcb_cell import lcb_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [IW-1:0]   my_idx,
  input  lcb_ctrl_t       ctrl,
  output lcb_cell_t       stat
);

  logic [KEY_BITS-1:0]    key_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic [SIZE_BITS-1:0]   size_r;
  logic                   valid_r, batch_r;
  logic [IW-1:0]          rank_r;
  logic                   me;

  assign me = (ctrl.sel_idx == my_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      batch_r <= 1'b0;
      rank_r  <= my_idx;
    end else begin
      if (ctrl.clr_batch) batch_r <= 1'b0;
      if (ctrl.evict && rank_r == ctrl.walk_rank) valid_r <= 1'b0;
      if (ctrl.wr && me) begin
        valid_r <= 1'b1;
        batch_r <= 1'b1;
      end
      if (ctrl.promote) begin
        if (me) rank_r <= '0;
        else if (rank_r < ctrl.promote_rank) rank_r <= rank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr && me) begin
      key_r    <= ctrl.key;
      handle_r <= ctrl.handle;
      size_r   <= ctrl.size;
    end
  end

  assign stat.hit      = valid_r && (key_r == ctrl.key);
  assign stat.walk_hit = (rank_r == ctrl.walk_rank);
  assign stat.valid    = valid_r;
  assign stat.batch    = batch_r;
  assign stat.rank     = rank_r;
  assign stat.key      = key_r;
  assign stat.handle   = handle_r;
  assign stat.size     = size_r;

endmodule

>>> rtl/lru_cache_byte_budget_core.sv
// Top level of the LRU byte-budget table: request sequencer, byte total
// and result register over a row of lcb_cell entries. Depends on lcb_pkg, lcb_cell.
//
// A request is taken when start is high and busy low. Lookup and advance give
// one result, registered after the S_LOOK state; an insert that is not rejected
// passes through S_LOOK, S_ADD, the eviction walk (S_WALK) and S_STORE, where the
// walk visits one recency rank a cycle, up to DEPTH ranks. Results appear for one
// cycle on out_valid and cannot be stalled; out_last marks the final one of a
// request. Unused command code 3 gives no result.
module lru_cache_byte_budget_core import lcb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_cmd,
  input  logic [KEY_BITS-1:0]    in_key,
  input  logic [HANDLE_BITS-1:0] in_handle,
  input  logic [SIZE_BITS-1:0]   in_entry_bytes,
  input  logic                   cfg_we,
  input  logic [BYTES_BITS-1:0]  cfg_wdata,
  output logic                   out_valid,
  output logic [2:0]             out_status,
  output logic [KEY_BITS-1:0]    out_key,
  output logic [HANDLE_BITS-1:0] out_handle,
  output logic [BYTES_BITS-1:0]  out_bytes_in_use,
  output logic                   out_last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_STORE = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [1:0]             cmd_r;
  logic [KEY_BITS-1:0]    key_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic [SIZE_BITS-1:0]   size_r;
  logic [BYTES_BITS-1:0]  limit_r, total_r, total_nxt;
  logic [IW-1:0]          rank_r, rank_nxt, cnt_r, cnt_nxt, slot_r, slot_nxt;
  logic                   need_r, need_nxt;

  lcb_ctrl_t ctrl;
  lcb_cell_t cells [DEPTH];

  logic [DEPTH-1:0]       hitv;
  logic                   any_hit, any_free, any_evict;
  logic [IW-1:0]          hit_idx, free_idx;
  logic [SIZE_BITS-1:0]   hit_size;
  logic [HANDLE_BITS-1:0] hit_handle;
  logic                   w_valid, w_batch, w_hit;
  logic [KEY_BITS-1:0]    w_key;
  logic [HANDLE_BITS-1:0] w_handle;
  logic [SIZE_BITS-1:0]   w_size;
  logic [IW-1:0]          sel_rank;

  logic                   em_v, em_last;
  logic [2:0]             em_st;
  logic [KEY_BITS-1:0]    em_key;
  logic [HANDLE_BITS-1:0] em_handle;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    lcb_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .my_idx (IW'(g)),
      .ctrl   (ctrl),
      .stat   (cells[g])
    );
    assign hitv[g] = cells[g].hit;
  end

  always_comb begin
    any_hit = 1'b0; any_free = 1'b0; any_evict = 1'b0;
    hit_idx = '0; free_idx = '0; hit_size = '0; hit_handle = '0;
    w_valid = 1'b0; w_batch = 1'b0; w_hit = 1'b0;
    w_key = '0; w_handle = '0; w_size = '0; sel_rank = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cells[i].hit) begin
        any_hit    = 1'b1;
        hit_idx    = IW'(i);
        hit_size   = hit_size | cells[i].size;
        hit_handle = hit_handle | cells[i].handle;
      end
      if (!cells[i].valid) begin
        any_free = 1'b1;
        free_idx = IW'(i);
      end
      if (cells[i].valid && !cells[i].batch) any_evict = 1'b1;
      if (cells[i].walk_hit) begin
        w_valid  = cells[i].valid;
        w_batch  = cells[i].batch;
        w_hit    = cells[i].hit;
        w_key    = cells[i].key;
        w_handle = cells[i].handle;
        w_size   = cells[i].size;
      end
      if (ctrl.sel_idx == IW'(i)) sel_rank = cells[i].rank;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r;
    rank_nxt  = rank_r;
    cnt_nxt   = cnt_r;
    slot_nxt  = slot_r;
    need_nxt  = need_r;
    em_v = 1'b0; em_last = 1'b0; em_st = ST_HIT; em_key = '0; em_handle = '0;
    ctrl = '0;
    ctrl.key          = key_r;
    ctrl.handle       = handle_r;
    ctrl.size         = size_r;
    ctrl.walk_rank    = rank_r;
    ctrl.sel_idx      = slot_r;
    ctrl.promote_rank = sel_rank;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = S_IDLE;
        case (cmd_r)
          CMD_LOOKUP: begin
            em_v = 1'b1; em_last = 1'b1; em_key = key_r;
            if (any_hit) begin
              em_st = ST_HIT; em_handle = hit_handle;
              ctrl.sel_idx = hit_idx; ctrl.promote = 1'b1;
            end else begin
              em_st = ST_MISS;
            end
          end
          CMD_ADVANCE: begin
            ctrl.clr_batch = 1'b1;
            em_v = 1'b1; em_last = 1'b1; em_st = ST_ADVANCED;
          end
          CMD_INSERT: begin
            need_nxt = !any_hit && !any_free;
            slot_nxt = any_hit ? hit_idx : free_idx;
            if (!any_hit && !any_free && !any_evict) begin
              em_v = 1'b1; em_last = 1'b1; em_st = ST_REJECTED; em_key = key_r;
            end else begin
              if (any_hit) total_nxt = sat_sub(total_r, hit_size);
              state_nxt = S_ADD;
            end
          end
          default: ;
        endcase
      end
      S_ADD: begin
        total_nxt = sat_add(total_r, size_r);
        rank_nxt  = IW'(DEPTH - 1);
        cnt_nxt   = '0;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (cnt_r == IW'(DEPTH - 1) || !(total_r > limit_r || need_r)) begin
          state_nxt = S_STORE;
        end else begin
          if (w_valid && !w_hit && !w_batch) begin
            ctrl.evict = 1'b1;
            total_nxt  = sat_sub(total_r, w_size);
            em_v = 1'b1; em_st = ST_EVICTED; em_key = w_key; em_handle = w_handle;
            cnt_nxt = cnt_r + 1'b1;
            if (need_r) begin
              need_nxt = 1'b0;
              for (int i = 0; i < DEPTH; i++)
                if (cells[i].walk_hit) slot_nxt = IW'(i);
            end
          end
          rank_nxt = rank_r - 1'b1;
          if (rank_r == '0) state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        ctrl.wr = 1'b1; ctrl.promote = 1'b1;
        em_v = 1'b1; em_last = 1'b1; em_st = ST_STORED; em_key = key_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      total_r   <= '0;
      limit_r   <= LIMIT_RESET;
      out_valid <= 1'b0;
      need_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      total_r   <= total_nxt;
      need_r    <= need_nxt;
      out_valid <= em_v;
      if (cfg_we) limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
    cnt_r  <= cnt_nxt;
    slot_r <= slot_nxt;
    if (state_r == S_IDLE && start) begin
      cmd_r    <= in_cmd;
      key_r    <= in_key;
      handle_r <= in_handle;
      size_r   <= in_entry_bytes;
    end
    out_status       <= em_st;
    out_key          <= em_key;
    out_handle       <= em_handle;
    out_bytes_in_use <= total_nxt;
    out_last         <= em_last;
  end

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy) else $error("last result while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request not taken");
  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hitv)) else $error("duplicate key in table");
  a_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EVICTED |-> !out_last) else $error("eviction marked last");

endmodule

>>> dv/lru_cache_byte_budget_checker.sv
// Checker for lru_cache_byte_budget_core: watches requests, results and register
// writes, keeps its own copy of the LRU table and compares every result.
// Depends on lcb_pkg.
module lru_cache_byte_budget_checker import lcb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  logic [1:0]             in_cmd,
  input  logic [KEY_BITS-1:0]    in_key,
  input  logic [HANDLE_BITS-1:0] in_handle,
  input  logic [SIZE_BITS-1:0]   in_entry_bytes,
  input  logic                   cfg_we,
  input  logic [BYTES_BITS-1:0]  cfg_wdata,
  input  logic                   out_valid,
  input  logic [2:0]             out_status,
  input  logic [KEY_BITS-1:0]    out_key,
  input  logic [HANDLE_BITS-1:0] out_handle,
  input  logic [BYTES_BITS-1:0]  out_bytes_in_use,
  input  logic                   out_last,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic [2:0]             status;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
    logic [BYTES_BITS-1:0]  bytes;
    logic                   last;
  } cache_result_t;

  cache_result_t          awaited_results[$];
  logic [KEY_BITS-1:0]    tbl_key[DEPTH];
  logic [HANDLE_BITS-1:0] tbl_handle[DEPTH];
  logic [SIZE_BITS-1:0]   tbl_size[DEPTH];
  bit                     tbl_valid[DEPTH];
  bit                     tbl_batch[DEPTH];
  int                     tbl_rank[DEPTH];
  logic [BYTES_BITS-1:0]  total_bytes;
  logic [BYTES_BITS-1:0]  budget;

  assign pending = awaited_results.size();

  function automatic logic [BYTES_BITS-1:0] add_bytes(logic [BYTES_BITS-1:0] t,
                                                      logic [SIZE_BITS-1:0] v);
    logic [BYTES_BITS:0] s;
    s = {1'b0, t} + (BYTES_BITS+1)'(v);
    return (s > BYTES_MAX) ? BYTES_MAX : s[BYTES_BITS-1:0];
  endfunction

  function automatic logic [BYTES_BITS-1:0] sub_bytes(logic [BYTES_BITS-1:0] t,
                                                      logic [SIZE_BITS-1:0] v);
    return (BYTES_BITS'(v) > t) ? '0 : t - BYTES_BITS'(v);
  endfunction

  task automatic push_result(logic [2:0] st, logic [KEY_BITS-1:0] k,
                             logic [HANDLE_BITS-1:0] h);
    cache_result_t e;
    e.status = st; e.key = k; e.handle = h; e.bytes = total_bytes; e.last = 1'b0;
    awaited_results = {awaited_results, e};
  endtask

  task automatic promote(int s);
    int r;
    r = tbl_rank[s];
    for (int i = 0; i < DEPTH; i++) if (tbl_rank[i] < r) tbl_rank[i]++;
    tbl_rank[s] = 0;
  endtask

  task automatic predict_request(logic [1:0] cmd, logic [KEY_BITS-1:0] k,
                                 logic [HANDLE_BITS-1:0] h, logic [SIZE_BITS-1:0] sz);
    int m, fs, slot, s, n;
    bit need, any;
    m = -1; fs = -1; n = 0; any = 0;
    for (int i = 0; i < DEPTH; i++) if (m < 0 && tbl_valid[i] && tbl_key[i] == k) m = i;
    if (cmd == CMD_LOOKUP) begin
      if (m < 0) push_result(ST_MISS, k, '0);
      else begin
        promote(m);
        push_result(ST_HIT, k, tbl_handle[m]);
      end
      n = 1;
    end else if (cmd == CMD_ADVANCE) begin
      for (int i = 0; i < DEPTH; i++) tbl_batch[i] = 0;
      push_result(ST_ADVANCED, '0, '0);
      n = 1;
    end else if (cmd == CMD_INSERT) begin
      for (int i = DEPTH - 1; i >= 0; i--) if (!tbl_valid[i]) fs = i;
      need = (m < 0 && fs < 0);
      for (int i = 0; i < DEPTH; i++) if (tbl_valid[i] && !tbl_batch[i]) any = 1;
      if (need && !any) begin
        push_result(ST_REJECTED, k, '0);
        n = 1;
      end else begin
        if (m >= 0) total_bytes = sub_bytes(total_bytes, tbl_size[m]);
        total_bytes = add_bytes(total_bytes, sz);
        for (int r = DEPTH - 1; r >= 0 && n < DEPTH - 1; r--) begin
          if (!(total_bytes > budget || need)) break;
          s = 0;
          for (int i = 0; i < DEPTH; i++) if (tbl_rank[i] == r) s = i;
          if (!tbl_valid[s] || s == m || tbl_batch[s]) continue;
          tbl_valid[s] = 0;
          total_bytes = sub_bytes(total_bytes, tbl_size[s]);
          push_result(ST_EVICTED, tbl_key[s], tbl_handle[s]);
          n++;
          if (need) begin
            need = 0;
            fs = s;
          end
        end
        slot = (m >= 0) ? m : fs;
        if (slot < 0) slot = 0;
        tbl_key[slot] = k; tbl_handle[slot] = h; tbl_size[slot] = sz;
        tbl_valid[slot] = 1; tbl_batch[slot] = 1;
        promote(slot);
        push_result(ST_STORED, k, '0);
        n++;
      end
    end
    if (n > 0) awaited_results[awaited_results.size() - 1].last = 1'b1;
  endtask

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    cache_result_t e;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        tbl_key[i] = '0; tbl_handle[i] = '0; tbl_size[i] = '0;
        tbl_valid[i] = 0; tbl_batch[i] = 0; tbl_rank[i] = i;
      end
      total_bytes = '0;
      budget = LIMIT_RESET;
      awaited_results.delete();
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) report("result with no request outstanding");
        else begin
          e = awaited_results.pop_front();
          if (out_status !== e.status)
            report($sformatf("status %0d, want %0d", out_status, e.status));
          if (out_key !== e.key) report($sformatf("key %h, want %h", out_key, e.key));
          if (out_handle !== e.handle)
            report($sformatf("handle %h, want %h", out_handle, e.handle));
          if (out_bytes_in_use !== e.bytes)
            report($sformatf("bytes %0d, want %0d", out_bytes_in_use, e.bytes));
          if (out_last !== e.last) report($sformatf("last %b, want %b", out_last, e.last));
        end
      end
      if (cfg_we) budget = cfg_wdata;
      if (start && !busy) predict_request(in_cmd, in_key, in_handle, in_entry_bytes);
    end
  end

endmodule

>>> dv/testbench.sv
// Top of the lru_cache_byte_budget_core testbench: clock, reset, directed and
// random requests, register writes and the verdict. Depends on lcb_pkg, the
// core and lru_cache_byte_budget_checker.
module testbench;
  import lcb_pkg::*;

  logic                   clk = 0;
  logic                   rst_n = 0;
  logic                   start = 0;
  logic                   busy;
  logic [1:0]             in_cmd = '0;
  logic [KEY_BITS-1:0]    in_key = '0;
  logic [HANDLE_BITS-1:0] in_handle = '0;
  logic [SIZE_BITS-1:0]   in_entry_bytes = '0;
  logic                   cfg_we = 0;
  logic [BYTES_BITS-1:0]  cfg_wdata = '0;
  logic                   out_valid;
  logic [2:0]             out_status;
  logic [KEY_BITS-1:0]    out_key;
  logic [HANDLE_BITS-1:0] out_handle;
  logic [BYTES_BITS-1:0]  out_bytes_in_use;
  logic                   out_last;
  int                     fail_count;
  int                     pending;
  logic [KEY_BITS-1:0]    key_pool[24];
  bit                     calm;

  always #10 clk = ~clk;

  lru_cache_byte_budget_core DUT (.*);
  lru_cache_byte_budget_checker u_checker (.*);

  task automatic send(logic [1:0] c, logic [KEY_BITS-1:0] k,
                      logic [HANDLE_BITS-1:0] h, logic [SIZE_BITS-1:0] b);
    start <= 1'b1; in_cmd <= c; in_key <= k; in_handle <= h; in_entry_bytes <= b;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // drain, then allow for a silent request still in flight
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
  endtask

  task automatic write_budget(logic [BYTES_BITS-1:0] v);
    drain();
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    int sel;
    logic [1:0] c;
    logic [KEY_BITS-1:0] k;
    logic [SIZE_BITS-1:0] b;
    sel = $urandom_range(0, 99);
    c = (sel < 50) ? CMD_INSERT : (sel < 85) ? CMD_LOOKUP :
        (sel < 95) ? CMD_ADVANCE : CMD_UNUSED;
    k = ($urandom_range(0, 4) != 0) ? key_pool[$urandom_range(0, 23)] : $urandom;
    b = $urandom_range(0, 1) ? SIZE_BITS'($urandom_range(0, 4000000)) : SIZE_BITS'($urandom);
    send(c, k, HANDLE_BITS'($urandom), b);
    if (!calm && $urandom_range(0, 3) == 0) pause($urandom_range(1, 16));
  endtask

  initial #(20 * 2000000) begin
    $display("lru_cache_byte_budget_core test failed");
    $finish;
  end

  initial begin
    calm = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send(CMD_UNUSED, $urandom, HANDLE_BITS'($urandom), SIZE_BITS'($urandom));
    send(CMD_LOOKUP, '0, '0, '0);
    send(CMD_INSERT, '0, '0, '0);
    send(CMD_INSERT, '1, '1, '1);
    send(CMD_LOOKUP, '1, '0, '0);
    send(CMD_INSERT, '1, 16'h1234, 24'd5);
    send(CMD_ADVANCE, '0, '0, '0);
    write_budget(BYTES_MAX);
    for (int i = 0; i < DEPTH; i++)
      send(CMD_INSERT, KEY_BITS'(100 + i), HANDLE_BITS'(i), 24'hFFFFFF);
    send(CMD_INSERT, 32'd200, 16'h55, 24'd1);
    send(CMD_ADVANCE, '0, '0, '0);
    send(CMD_INSERT, 32'd201, 16'h66, 24'd2);
    send(CMD_LOOKUP, 32'd105, '0, '0);
    write_budget('0);
    send(CMD_ADVANCE, '0, '0, '0);
    send(CMD_INSERT, 32'd202, 16'h77, 24'd3);

    // random phases across several budgets
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_budget(LIMIT_RESET);
        1: write_budget(BYTES_MAX);
        2: write_budget(BYTES_BITS'($urandom_range(1, 40000000)));
        3: write_budget('0);
        default: write_budget(BYTES_BITS'($urandom));
      endcase
      calm = (ph == 4) && 1'b1;
      for (int i = 0; i < 86; i++) begin
        if (ph == 4 && i < 40) calm = 0;
        else if (ph == 4) calm = 1;
        random_request();
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("lru_cache_byte_budget_core test passed");
    end else begin
      $display("lru_cache_byte_budget_core test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/lcb_pkg.sv
rtl/lcb_cell.sv
rtl/lru_cache_byte_budget_core.sv
dv/lru_cache_byte_budget_checker.sv
dv/testbench.sv
